### src/ccte_pkg.sv
// ----------------------------------------------------------------------------
// Cluster chain table engine package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package ccte_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int CW          = 12;
    localparam int EW          = 16;

    localparam logic [EW-1:0] ENT_FREE = 16'h0000;
    localparam logic [EW-1:0] ENT_END  = 16'h0001;
    localparam logic [EW-1:0] ENT_RSV  = 16'hFFFF;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_LINK  = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_SKIP  = 3'd3;
    localparam logic [2:0] OP_WRITE = 3'd4;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_FULL      = 4'd1;
    localparam logic [3:0] ST_LNK_SRC   = 4'd2;
    localparam logic [3:0] ST_LNK_TGT   = 4'd3;
    localparam logic [3:0] ST_LNK_END   = 4'd4;
    localparam logic [3:0] ST_FREE_TWO  = 4'd5;
    localparam logic [3:0] ST_FREE_BAD  = 4'd6;
    localparam logic [3:0] ST_FREE_FREE = 4'd7;
    localparam logic [3:0] ST_FREE_RSV  = 4'd8;
    localparam logic [3:0] ST_WALK_BAD  = 4'd9;
    localparam logic [3:0] ST_WALK_NXT  = 4'd10;
    localparam logic [3:0] ST_WALK_RSV  = 4'd11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic rd_cur;     // read the entry of the current cluster
        logic rd_scan;    // read the entry at the scan pointer
        logic scan_inc;   // advance the scan pointer
        logic scan_clr;   // restart the scan at zero
        logic fill_wr;    // write one entry of the group being opened
        logic fill_inc;   // advance the fill pointer
        logic fill_start; // point the fill at the next group
        logic grp_inc;    // one more group is open
        logic wr_end_scan;// mark scan entry end of chain, take it as the allocation
        logic wr_end_new; // mark the first free entry of the new group end of chain
        logic wr_link;    // current entry = target
        logic wr_free;    // current entry = free, follow old value
        logic wr_lnk_alloc;// current entry = allocated cluster, move there
        logic step;       // apply one walk step within the current cluster
        logic walk_init;  // move to the next cluster, position zero
        logic pos_end;    // position becomes the cluster size at a chain end
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // scan pointer at the last entry of the open groups
        logic scan_none;   // no open group to scan
        logic scan_hit;    // read scan entry is free
        logic can_open;    // a new group fits
        logic fill_last;   // fill pointer at the last entry of the group
        logic cur_valid;   // current cluster lies in an open group
        logic tgt_valid;   // target lies in an open group
        logic cur_first;   // current cluster is the first of its group
        logic cur_two;     // current cluster is cluster 2
        logic len_zero;    // no bytes left
        logic past_end;    // position at or beyond the cluster size
        logic step_past;   // position reaches cluster size after this step
        logic [EW-1:0] ent;// entry just read
    } t_sts;

endpackage

### src/ccte_datapath.sv
// ----------------------------------------------------------------------------
// Cluster chain table engine datapath
// Chain table memory, scan and fill pointers, walk registers and results.
// ----------------------------------------------------------------------------
module ccte_datapath
    import ccte_pkg::*;
#(
    parameter int CLUSTERS_PER_GROUP = 1024,
    parameter int MAX_GROUPS         = 4,
    parameter int BYTES_PER_CLUSTER  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_opcode,
    input  logic [11:0] i_cluster_in,
    input  logic [11:0] i_target,
    input  logic [12:0] i_offset_in,
    input  logic [31:0] i_length,
    output logic [2:0]  o_op,
    output logic [11:0] o_cluster_out,
    output logic [12:0] o_offset_out,
    output logic [31:0] o_count,
    output logic        o_first_valid,
    output logic [11:0] o_first_cluster,
    output logic [11:0] o_first_offset
);

    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam int BW = 17;
    localparam logic [BW-1:0] BPC = BW'(BYTES_PER_CLUSTER);
    localparam int CPG_L = (CLUSTERS_PER_GROUP > TABLE_DEPTH) ? TABLE_DEPTH
                                                              : CLUSTERS_PER_GROUP;

    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;

    logic [GW-1:0] r_grp;
    logic [2:0]    r_op;
    logic [CW-1:0] r_cur, r_tgt, r_scan, r_alloc, r_fc;
    logic [12:0]   r_fill;
    logic [12:0]   r_base;
    logic [BW-1:0] r_pos, r_fo;
    logic [31:0]   r_len, r_done;
    logic          r_got;

    // Number of table entries covered by the open groups.
    logic [23:0] open_lim;
    assign open_lim = 24'(r_grp) * 24'(CLUSTERS_PER_GROUP);

    function automatic logic in_open(input logic [CW-1:0] c, input logic [23:0] lim);
        in_open = 24'(c) < lim;
    endfunction

    logic [BW-1:0] room, stp;
    logic [31:0]   stp32;
    logic [23:0]   nb;
    logic [12:0]   first_new;
    logic          cur_first;

    assign nb        = 24'(r_grp) * 24'(CLUSTERS_PER_GROUP);
    assign first_new = (r_grp == '0) ? 13'd2 : 13'd1;
    assign room      = (r_pos < BPC) ? BPC - r_pos : '0;
    assign stp       = (r_len < 32'(room)) ? r_len[BW-1:0] : room;
    assign stp32     = 32'(stp);

    // The current cluster is the first of a group when it equals a group base.
    always_comb begin
        cur_first = 1'b0;
        for (int k = 0; k < MAX_GROUPS; k++) begin
            if (24'(r_cur) == 24'(k * CLUSTERS_PER_GROUP)) cur_first = 1'b1;
        end
    end

    always_comb begin
        o_sts.scan_none = (r_grp == '0);
        o_sts.scan_last = (24'(r_scan) + 24'd1 >= open_lim)
                          || (r_scan == CW'(TABLE_DEPTH - 1));
        o_sts.scan_hit  = (r_rd == ENT_FREE);
        o_sts.can_open  = (int'(r_grp) < MAX_GROUPS)
                          && (nb + 24'(first_new) < 24'(TABLE_DEPTH));
        o_sts.fill_last = (r_fill == 13'(CPG_L - 1))
                          || (24'(r_base) + 24'(r_fill) >= 24'(TABLE_DEPTH - 1));
        o_sts.cur_valid = in_open(r_cur, open_lim);
        o_sts.tgt_valid = in_open(r_tgt, open_lim);
        o_sts.cur_first = cur_first;
        o_sts.cur_two   = (r_cur == CW'(2));
        o_sts.len_zero  = (r_len == '0);
        o_sts.past_end  = (r_pos >= BPC);
        o_sts.step_past = (r_pos + stp >= BPC);
        o_sts.ent       = r_rd;
    end

    logic [CW-1:0] wa;
    logic [EW-1:0] wd;
    logic          we;
    logic [CW-1:0] ra;
    logic [CW-1:0] fill_addr;

    assign fill_addr = CW'(r_base + r_fill);

    always_comb begin
        we = 1'b0;
        wa = r_cur;
        wd = ENT_FREE;
        if (i_cmd.fill_wr) begin
            we = 1'b1;
            wa = fill_addr;
            wd = ((r_fill == '0) || (r_grp == '0 && r_fill == 13'd1)) ? ENT_RSV : ENT_FREE;
        end else if (i_cmd.wr_end_scan) begin
            we = 1'b1;
            wa = r_scan;
            wd = ENT_END;
        end else if (i_cmd.wr_end_new) begin
            we = 1'b1;
            wa = CW'(r_base + first_new);
            wd = ENT_END;
        end else if (i_cmd.wr_link) begin
            we = 1'b1;
            wd = EW'(r_tgt);
        end else if (i_cmd.wr_free) begin
            we = 1'b1;
            wd = ENT_FREE;
        end else if (i_cmd.wr_lnk_alloc) begin
            we = 1'b1;
            wd = EW'(r_alloc);
        end
        ra = i_cmd.rd_scan ? r_scan : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else if (i_cmd.grp_inc) begin
            r_grp <= r_grp + GW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_cur  <= i_cluster_in;
            r_tgt  <= i_target;
            r_pos  <= BW'(i_offset_in);
            r_len  <= i_length;
            r_done <= '0;
            r_got  <= 1'b0;
            r_fc   <= '0;
            r_fo   <= '0;
            r_alloc <= '0;
        end
        if (i_cmd.scan_clr) r_scan <= '0;
        else if (i_cmd.scan_inc) r_scan <= r_scan + CW'(1);
        if (i_cmd.fill_start) begin
            r_base <= 13'(nb);
            r_fill <= '0;
        end else if (i_cmd.fill_inc) begin
            r_fill <= r_fill + 13'd1;
        end
        if (i_cmd.wr_end_scan) r_alloc <= r_scan;
        if (i_cmd.wr_end_new)  r_alloc <= CW'(r_base + first_new);
        if (i_cmd.wr_free) r_cur <= r_rd[CW-1:0];
        if (i_cmd.wr_lnk_alloc) begin
            r_cur <= r_alloc;
            r_pos <= '0;
        end
        if (i_cmd.step) begin
            if (stp != '0) begin
                if (!r_got) begin
                    r_fc  <= r_cur;
                    r_fo  <= r_pos;
                    r_got <= 1'b1;
                end
                r_len  <= r_len - stp32;
                r_pos  <= r_pos + stp;
                r_done <= r_done + stp32;
            end
        end
        if (i_cmd.walk_init) begin
            // move to the next cluster in the chain
            r_cur <= r_rd[CW-1:0];
            r_pos <= '0;
        end
        if (i_cmd.pos_end) r_pos <= BPC;
    end

    assign o_op            = r_op;
    assign o_cluster_out   = (r_op == OP_ALLOC) ? r_alloc : r_cur;
    assign o_offset_out    = r_pos[12:0];
    assign o_count         = r_done;
    assign o_first_valid   = r_got;
    assign o_first_cluster = r_fc;
    assign o_first_offset  = r_fo[11:0];

endmodule

### src/ccte_ctrl.sv
// ----------------------------------------------------------------------------
// Cluster chain table engine controller
// Sequences allocation scans, group opening, links, frees and walks.
// ----------------------------------------------------------------------------
module ccte_ctrl
    import ccte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  i_opcode,
    input  t_sts        i_sts,
    output t_cmd        o_cmd,
    output logic [3:0]  o_status,
    output logic        o_zero
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DISP   = 14'b00000000000010,
        S_SRD    = 14'b00000000000100,
        S_SCHK   = 14'b00000000001000,
        S_FILL   = 14'b00000000010000,
        S_NEWEND = 14'b00000000100000,
        S_LRD    = 14'b00000001000000,
        S_LCHK   = 14'b00000010000000,
        S_FRD    = 14'b00000100000000,
        S_FCHK   = 14'b00001000000000,
        S_WCHK   = 14'b00010000000000,
        S_WRD    = 14'b00100000000000,
        S_WNXT   = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } t_state;

    t_state       r_state, n_state;
    logic [3:0]   r_status, n_status;
    logic [12:0]  r_steps, n_steps;
    logic         r_walloc, n_walloc; // allocation on behalf of a write walk
    logic         r_zero, n_zero;

    logic is_wr;
    assign is_wr = (i_opcode == OP_WRITE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_steps  = r_steps;
        n_walloc = r_walloc;
        n_zero   = r_zero;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_status   = ST_OK;
                    n_steps    = '0;
                    n_walloc   = 1'b0;
                    n_zero     = 1'b0;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_opcode)
                    OP_ALLOC: begin
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SRD;
                    end
                    OP_LINK: begin
                        if (!i_sts.cur_valid) begin
                            n_status = ST_LNK_SRC; n_state = S_DONE;
                        end else if (!i_sts.tgt_valid) begin
                            n_status = ST_LNK_TGT; n_state = S_DONE;
                        end else begin
                            n_state = S_LRD;
                        end
                    end
                    OP_FREE: n_state = S_FRD;
                    OP_SKIP, OP_WRITE: n_state = S_WCHK;
                    default: begin
                        n_zero  = 1'b1;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SRD: begin
                if (i_sts.scan_none) begin
                    if (i_sts.can_open) begin
                        o_cmd.fill_start = 1'b1;
                        n_state = S_FILL;
                    end else begin
                        n_status = ST_FULL; n_state = S_DONE;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_sts.scan_hit) begin
                    o_cmd.wr_end_scan = 1'b1;
                    n_state = r_walloc ? S_WNXT : S_DONE;
                end else if (i_sts.scan_last) begin
                    if (i_sts.can_open) begin
                        o_cmd.fill_start = 1'b1;
                        n_state = S_FILL;
                    end else begin
                        n_status = ST_FULL; n_state = S_DONE;
                    end
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_FILL: begin
                o_cmd.fill_wr  = 1'b1;
                o_cmd.fill_inc = 1'b1;
                if (i_sts.fill_last) n_state = S_NEWEND;
            end
            S_NEWEND: begin
                o_cmd.wr_end_new = 1'b1;
                o_cmd.grp_inc    = 1'b1;
                n_state = r_walloc ? S_WNXT : S_DONE;
            end
            S_LRD: begin
                o_cmd.rd_cur = 1'b1;
                n_state = S_LCHK;
            end
            S_LCHK: begin
                if (i_sts.ent != ENT_END) n_status = ST_LNK_END;
                else o_cmd.wr_link = 1'b1;
                n_state = S_DONE;
            end
            S_FRD: begin
                if (r_steps > 13'(TABLE_DEPTH)) begin
                    n_status = ST_FREE_FREE; n_state = S_DONE;
                end else if (i_sts.cur_two) begin
                    n_status = ST_FREE_TWO; n_state = S_DONE;
                end else if (!i_sts.cur_valid) begin
                    n_status = ST_FREE_BAD; n_state = S_DONE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_sts.ent == ENT_FREE) begin
                    n_status = ST_FREE_FREE; n_state = S_DONE;
                end else if (i_sts.ent == ENT_RSV) begin
                    n_status = ST_FREE_RSV; n_state = S_DONE;
                end else begin
                    o_cmd.wr_free = 1'b1;
                    n_steps = r_steps + 13'd1;
                    n_state = (i_sts.ent == ENT_END) ? S_DONE : S_FRD;
                end
            end
            S_WCHK: begin
                if (!i_sts.cur_valid || i_sts.cur_first) begin
                    n_status = ST_WALK_BAD; n_state = S_DONE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                if (i_sts.ent == ENT_FREE) begin
                    n_status = ST_WALK_BAD; n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    if (!i_sts.step_past) begin
                        n_state = S_DONE;
                    end else if (i_sts.ent == ENT_END || i_sts.ent == ENT_RSV) begin
                        n_state = S_WNXT;
                    end else begin
                        // plain next link: stays in the loop if bytes remain
                        n_state = S_WNXT;
                    end
                end
            end
            S_WNXT: begin
                // Position is at or past the cluster end; entry in i_sts.ent.
                if (r_walloc) begin
                    o_cmd.wr_lnk_alloc = 1'b1;
                    n_walloc = 1'b0;
                    n_state  = i_sts.len_zero ? S_DONE : S_WCHK;
                end else if (i_sts.ent == ENT_FREE) begin
                    n_status = ST_WALK_NXT; n_state = S_DONE;
                end else if (!is_wr && (i_sts.ent == ENT_END || i_sts.ent == ENT_RSV)) begin
                    o_cmd.pos_end = 1'b1;
                    n_state = S_DONE;
                end else if (is_wr && i_sts.ent == ENT_RSV) begin
                    if (!i_sts.len_zero) n_status = ST_WALK_RSV;
                    n_state = S_DONE;
                end else if (is_wr && i_sts.ent == ENT_END) begin
                    if (i_sts.len_zero) begin
                        o_cmd.pos_end = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_walloc = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SRD;
                    end
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state = i_sts.len_zero ? S_DONE : S_WCHK;
                end
            end
            S_DONE: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_steps  <= '0;
            r_walloc <= 1'b0;
            r_zero   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_steps  <= n_steps;
            r_walloc <= n_walloc;
            r_zero   <= n_zero;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_status = r_status;
    assign o_zero   = r_zero || (r_status != ST_OK);

endmodule

### src/cluster_chain_table_engine.sv
// ----------------------------------------------------------------------------
// Cluster chain table engine
// FAT-style next-cluster table with allocate, link, free, skip and write walks.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result item. Allocate reads
// the table entries one at a time through the memory read port, scanning
// each occupied entry ahead of the first free one, and writes every entry of
// a new group when one must be opened. Free reads and clears each cluster in
// the chain in turn, and walks read each cluster visited; a write walk may
// also allocate clusters on the way. Table entries of a group are first
// written when the group is opened, so no clearing pass follows reset.
module cluster_chain_table_engine
    import ccte_pkg::*;
#(
    parameter int CLUSTERS_PER_GROUP = 1024,
    parameter int MAX_GROUPS         = 4,
    parameter int BYTES_PER_CLUSTER  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [11:0] i_cluster_in,
    input  logic [11:0] i_target,
    input  logic [12:0] i_offset_in,
    input  logic [31:0] i_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [11:0] o_cluster_out,
    output logic [12:0] o_offset_out,
    output logic [31:0] o_count,
    output logic        o_first_valid,
    output logic [11:0] o_first_cluster,
    output logic [11:0] o_first_offset
);

    t_cmd        cmd;
    t_sts        sts;
    logic [2:0]  op;
    logic        zero;
    logic [11:0] d_cl, d_fc, d_fo;
    logic [12:0] d_off;
    logic [31:0] d_cnt;
    logic        d_fv;

    ccte_datapath #(
        .CLUSTERS_PER_GROUP(CLUSTERS_PER_GROUP),
        .MAX_GROUPS        (MAX_GROUPS),
        .BYTES_PER_CLUSTER (BYTES_PER_CLUSTER)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_opcode),
        .i_cluster_in   (i_cluster_in),
        .i_target       (i_target),
        .i_offset_in    (i_offset_in),
        .i_length       (i_length),
        .o_op           (op),
        .o_cluster_out  (d_cl),
        .o_offset_out   (d_off),
        .o_count        (d_cnt),
        .o_first_valid  (d_fv),
        .o_first_cluster(d_fc),
        .o_first_offset (d_fo)
    );

    ccte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_opcode(op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_status(o_status),
        .o_zero  (zero)
    );

    // Fields an operation does not define are forced to zero.
    logic is_alloc, is_walk, is_wr;
    assign is_alloc = (op == OP_ALLOC);
    assign is_wr    = (op == OP_WRITE);
    assign is_walk  = (op == OP_SKIP) || is_wr;

    assign o_cluster_out   = (zero || !(is_alloc || is_walk)) ? '0 : d_cl;
    assign o_offset_out    = (zero || !is_walk) ? '0 : d_off;
    assign o_count         = (zero || op != OP_SKIP) ? '0 : d_cnt;
    assign o_first_valid   = (zero || !is_wr) ? 1'b0 : d_fv;
    assign o_first_cluster = (zero || !is_wr) ? '0 : d_fc;
    assign o_first_offset  = (zero || !is_wr) ? '0 : d_fo;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Cluster chain table engine testbench
// A queue-fed driver sends directed and then random operations with bursts
// and gaps. The receiver stalls on its own pattern and holds off once for a
// long stretch. A chain table model in the testbench predicts each result.
// ----------------------------------------------------------------------------
module tb;
    import ccte_pkg::*;

    localparam int CPG = 1024;
    localparam int NGRP = 4;
    localparam int BPC = 4096;
    localparam int N_RANDOM = 430;

    typedef struct {
        logic [2:0]  op;
        logic [11:0] clu;
        logic [11:0] tgt;
        logic [12:0] off;
        logic [31:0] len;
    } op_item_t;

    typedef struct {
        logic [3:0]  status;
        logic [11:0] clu;
        logic [12:0] off;
        logic [31:0] cnt;
        logic        fv;
        logic [11:0] fc;
        logic [11:0] fo;
    } walk_res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_opcode;
    logic [11:0] i_cluster_in;
    logic [11:0] i_target;
    logic [12:0] i_offset_in;
    logic [31:0] i_length;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_status;
    logic [11:0] o_cluster_out;
    logic [12:0] o_offset_out;
    logic [31:0] o_count;
    logic        o_first_valid;
    logic [11:0] o_first_cluster;
    logic [11:0] o_first_offset;

    cluster_chain_table_engine DUT (.*);

    // Testbench copy of the chain table and the number of opened groups.
    logic [15:0] chain_next [TABLE_DEPTH];
    int unsigned open_groups;

    op_item_t  pending_ops[$];
    walk_res_t expected_results[$];
    int        errors;
    logic      in_taken;
    int        burst_left;
    int        gap_left;
    int        hold_cycles;
    logic      hold_request;
    int        ready_mode;
    int        mode_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit cluster_ok(input int unsigned c);
        return c < TABLE_DEPTH && c / CPG < open_groups;
    endfunction

    // First-fit allocation; opens the next group when no entry is free.
    function automatic bit grab_cluster(output int unsigned got);
        int unsigned base;
        int unsigned first;
        int unsigned idx;
        got = 0;
        for (int unsigned g = 0; g < open_groups; g++) begin
            for (int unsigned j = 0; j < CPG; j++) begin
                idx = g * CPG + j;
                if (idx < TABLE_DEPTH && chain_next[idx] == ENT_FREE) begin
                    chain_next[idx] = ENT_END;
                    got = idx;
                    return 1'b1;
                end
            end
        end
        if (open_groups >= NGRP) return 1'b0;
        base = open_groups * CPG;
        first = (open_groups != 0) ? 1 : 2;
        if (base + first >= TABLE_DEPTH) return 1'b0;
        for (int unsigned i = 0; i < CPG; i++) begin
            if (base + i < TABLE_DEPTH)
                chain_next[base + i] = (i == 0 || (open_groups == 0 && i == 1)) ?
                                       ENT_RSV : ENT_FREE;
        end
        chain_next[base + first] = ENT_END;
        open_groups++;
        got = base + first;
        return 1'b1;
    endfunction

    function automatic logic [3:0] release_chain(input int unsigned start);
        int unsigned c;
        logic [15:0] old;
        c = start;
        for (int steps = 0; steps <= TABLE_DEPTH; steps++) begin
            if (c == 2) return ST_FREE_TWO;
            if (!cluster_ok(c)) return ST_FREE_BAD;
            old = chain_next[c];
            if (old == ENT_FREE) return ST_FREE_FREE;
            if (old == ENT_RSV) return ST_FREE_RSV;
            chain_next[c] = ENT_FREE;
            if (old == ENT_END) return ST_OK;
            c = old;
        end
        return ST_FREE_FREE;
    endfunction

    // Advances a byte position along a chain; a write walk grows the chain.
    function automatic logic [3:0] advance_position(input bit wr, input op_item_t it,
                                                    inout walk_res_t r);
        int unsigned c;
        int unsigned pos;
        int unsigned len;
        int unsigned done;
        int unsigned room;
        int unsigned stp;
        int unsigned n;
        int unsigned fc;
        int unsigned fo;
        bit got_first;
        c = it.clu;
        pos = it.off;
        len = it.len;
        done = 0;
        fc = 0;
        fo = 0;
        got_first = 0;
        do begin
            if (!cluster_ok(c) || c % CPG == 0 || chain_next[c] == ENT_FREE)
                return ST_WALK_BAD;
            room = (pos < BPC) ? BPC - pos : 0;
            stp = (len < room) ? len : room;
            if (stp != 0) begin
                if (!got_first) begin
                    fc = c;
                    fo = pos;
                    got_first = 1;
                end
                len -= stp;
                pos += stp;
                done += stp;
            end
            if (pos >= BPC) begin
                n = chain_next[c];
                if (n == ENT_FREE) return ST_WALK_NXT;
                if (!wr && (n == ENT_END || n == ENT_RSV)) begin
                    pos = BPC;
                    break;
                end
                if (wr && n == ENT_RSV) begin
                    if (len > 0) return ST_WALK_RSV;
                    break;
                end
                if (wr && n == ENT_END) begin
                    if (len == 0) begin
                        pos = BPC;
                        break;
                    end
                    if (!grab_cluster(n)) return ST_FULL;
                    chain_next[c] = n[15:0];
                end
                c = n;
                pos = 0;
            end
        end while (len > 0);
        r.clu = c[11:0];
        r.off = pos[12:0];
        r.cnt = wr ? 32'd0 : done;
        r.fv = wr && got_first;
        r.fc = wr ? fc[11:0] : 12'd0;
        r.fo = wr ? fo[11:0] : 12'd0;
        return ST_OK;
    endfunction

    function automatic walk_res_t predict_result(input op_item_t it);
        walk_res_t r;
        int unsigned got;
        r = '{default: '0};
        case (it.op)
            OP_ALLOC: begin
                if (grab_cluster(got)) r.clu = got[11:0];
                else r.status = ST_FULL;
            end
            OP_LINK: begin
                if (!cluster_ok(it.clu)) r.status = ST_LNK_SRC;
                else if (!cluster_ok(it.tgt)) r.status = ST_LNK_TGT;
                else if (chain_next[it.clu] != ENT_END) r.status = ST_LNK_END;
                else chain_next[it.clu] = {4'd0, it.tgt};
            end
            OP_FREE: r.status = release_chain(it.clu);
            OP_SKIP, OP_WRITE: r.status = advance_position(it.op == OP_WRITE, it, r);
            default: ;
        endcase
        if (r.status != ST_OK) r = '{status: r.status, default: '0};
        return r;
    endfunction

    function automatic op_item_t mk(input logic [2:0] op, input int c, input int t,
                                    input int o, input logic [31:0] l);
        op_item_t it;
        it.op = op;
        it.clu = c[11:0];
        it.tgt = t[11:0];
        it.off = o[12:0];
        it.len = l;
        return it;
    endfunction

    // Driver: inputs change at the falling edge. A burst of items is followed
    // by a random gap; valid is held with the payload until the item is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op_item_t it;
                it = pending_ops.pop_front();
                i_opcode <= it.op;
                i_cluster_in <= it.clu;
                i_target <= it.tgt;
                i_offset_in <= it.off;
                i_length <= it.len;
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern switches between three modes at random. One long
    // hold-off lets the sender pile up items against a busy block.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles = 400;
            i_ready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                mode_cycles = 64;
                ready_mode = $urandom_range(0, 2);
            end
            mode_cycles--;
            case (ready_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Monitor: input items are predicted as they are accepted, and each
    // result item is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready)
                expected_results.push_back(predict_result(
                    mk(i_opcode, i_cluster_in, i_target, i_offset_in, i_length)));
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    errors++;
                end else begin
                    walk_res_t w;
                    w = expected_results.pop_front();
                    if (o_status !== w.status)
                        report("status", 32'(o_status), 32'(w.status));
                    if (o_cluster_out !== w.clu)
                        report("cluster_out", 32'(o_cluster_out), 32'(w.clu));
                    if (o_offset_out !== w.off)
                        report("offset_out", 32'(o_offset_out), 32'(w.off));
                    if (o_count !== w.cnt) report("count", o_count, w.cnt);
                    if (o_first_valid !== w.fv)
                        report("first_valid", 32'(o_first_valid), 32'(w.fv));
                    if (o_first_cluster !== w.fc)
                        report("first_cluster", 32'(o_first_cluster), 32'(w.fc));
                    if (o_first_offset !== w.fo)
                        report("first_offset", 32'(o_first_offset), 32'(w.fo));
                end
            end
        end
    end

    // Small cluster numbers keep chains inside the clusters that first-fit
    // allocation actually hands out; a few numbers span the whole range.
    function automatic int pick_cluster();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
        return $urandom_range(0, 48);
    endfunction

    initial begin
        int r;
        errors = 0;
        burst_left = 0;
        gap_left = 0;
        hold_cycles = 0;
        hold_request = 1'b0;
        ready_mode = 0;
        mode_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_opcode = OP_ALLOC;
        i_cluster_in = '0;
        i_target = '0;
        i_offset_in = '0;
        i_length = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) chain_next[i] = ENT_FREE;
        open_groups = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: link errors, a self loop, walks past the chain end,
        // the largest length and offsets, and the undefined opcodes.
        pending_ops.push_back(mk(OP_ALLOC, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LINK, 2, 3, 0, 0));
        pending_ops.push_back(mk(OP_LINK, 2, 4, 0, 0));
        pending_ops.push_back(mk(OP_LINK, 1500, 3, 0, 0));
        pending_ops.push_back(mk(OP_LINK, 3, 4095, 0, 0));
        pending_ops.push_back(mk(OP_SKIP, 2, 0, 0, 32'hFFFF_FFFF));
        pending_ops.push_back(mk(OP_SKIP, 2, 0, 4096, 5));
        pending_ops.push_back(mk(OP_WRITE, 3, 0, 100, 10000));
        pending_ops.push_back(mk(OP_WRITE, 4, 0, 8191, 0));
        pending_ops.push_back(mk(OP_SKIP, 0, 0, 0, 1));
        pending_ops.push_back(mk(OP_SKIP, 100, 0, 0, 1));
        pending_ops.push_back(mk(OP_FREE, 2, 0, 0, 0));
        pending_ops.push_back(mk(OP_FREE, 1, 0, 0, 0));
        pending_ops.push_back(mk(OP_FREE, 4000, 0, 0, 0));
        pending_ops.push_back(mk(OP_LINK, 4, 0, 0, 0));
        pending_ops.push_back(mk(OP_SKIP, 4, 0, 4000, 200));
        pending_ops.push_back(mk(OP_FREE, 4, 0, 0, 0));
        pending_ops.push_back(mk(OP_FREE, 3, 0, 0, 0));
        pending_ops.push_back(mk(OP_FREE, 3, 0, 0, 0));
        pending_ops.push_back(mk(OP_ALLOC, 0, 0, 0, 0));
        pending_ops.push_back(mk(OP_LINK, 3, 3, 0, 0));
        pending_ops.push_back(mk(OP_FREE, 3, 0, 0, 0));
        pending_ops.push_back(mk(5, 4095, 4095, 8191, 32'hFFFF_FFFF));
        pending_ops.push_back(mk(6, 0, 0, 0, 0));
        pending_ops.push_back(mk(7, 0, 0, 0, 0));

        wait (pending_ops.size() == 0);
        hold_request = 1'b1;

        // Random part: a mix weighted toward allocations and links so that
        // chains grow, with frees and walks over those chains.
        for (int k = 0; k < N_RANDOM; k++) begin
            op_item_t it;
            r = $urandom_range(0, 99);
            it = mk(OP_ALLOC, pick_cluster(), pick_cluster(), 0, 0);
            if (r < 25) it.op = OP_ALLOC;
            else if (r < 47) it.op = OP_LINK;
            else if (r < 62) it.op = OP_FREE;
            else if (r < 79) it.op = OP_SKIP;
            else if (r < 96) it.op = OP_WRITE;
            else it.op = 3'($urandom_range(5, 7));
            it.off = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, 4096));
            it.len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 12288);
            pending_ops.push_back(it);
        end

        wait (pending_ops.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog: a generous bound on the whole run.
    initial begin
        #2000000000;
        $display("tb failed");
        $finish;
    end

endmodule
